>>> src/hsl_pkg.sv
// Shared types, widths and the divider step for the RGB to HSL converter.
package hsl_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int QW            = FRACTION_BITS + 1;
    localparam int DW            = 11;
    localparam int CW            = 8;
    localparam int SW            = 9;
    localparam int LATENCY       = FRACTION_BITS + 3;

    localparam logic [SW-1:0] CH_FULL  = 9'd255;
    localparam logic [SW-1:0] SUM_FULL = 9'd510;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [15:0] hue_out;
        logic [16:0] saturation_out;
        logic [8:0]  lightness_sum;
    } t_pix_out;

    typedef struct packed {
        logic [DW-1:0] rem;
        logic          nb;
        logic [DW-1:0] den;
        logic [QW-1:0] quo;
    } t_div_lane;

    typedef struct packed {
        logic          valid;
        t_div_lane     hue;
        t_div_lane     sat;
        logic [SW-1:0] sum;
    } t_div_word;

    function automatic t_div_lane div_step(input t_div_lane l);
        t_div_lane   res;
        logic [DW:0] part;
        logic [DW:0] den_x;
        logic [DW:0] diff;
        logic        qbit;
        part  = {l.rem, l.nb};
        den_x = {1'b0, l.den};
        diff  = part - den_x;
        qbit  = (part >= den_x);
        res.rem = qbit ? diff[DW-1:0] : part[DW-1:0];
        res.nb  = 1'b0;
        res.den = l.den;
        res.quo = {l.quo[QW-2:0], qbit};
        return res;
    endfunction

endpackage

>>> src/hsl_front.sv
// Front end: channel max/min and sector, then hue and saturation dividends and divisors.
module hsl_front
    import hsl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_pix_in   i_pix,
    output t_div_word o_word
);

    logic          r_v1;
    logic [CW-1:0] r_hi;
    logic [CW-1:0] r_lo;
    t_sector       r_sec;
    t_pix_in       r_pix;

    logic [CW-1:0] n_hi;
    logic [CW-1:0] n_lo;
    t_sector       n_sec;

    logic [CW-1:0] delta;
    logic [SW-1:0] sum;
    logic [DW-1:0] d6;
    logic [DW:0]   num;
    logic [SW-1:0] sat_den;
    logic          grey;
    t_div_word     n_word;
    t_div_word     r_word;

    always_comb begin
        n_lo = i_pix.red_in;
        if (i_pix.green_in < n_lo) begin
            n_lo = i_pix.green_in;
        end
        if (i_pix.blue_in < n_lo) begin
            n_lo = i_pix.blue_in;
        end
        if (i_pix.red_in >= i_pix.green_in && i_pix.red_in >= i_pix.blue_in) begin
            n_sec = SEC_RED;
            n_hi  = i_pix.red_in;
        end else if (i_pix.green_in >= i_pix.blue_in) begin
            n_sec = SEC_GREEN;
            n_hi  = i_pix.green_in;
        end else begin
            n_sec = SEC_BLUE;
            n_hi  = i_pix.blue_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_hi  <= n_hi;
        r_lo  <= n_lo;
        r_sec <= n_sec;
        r_pix <= i_pix;
    end

    always_comb begin
        delta = r_hi - r_lo;
        sum   = {1'b0, r_hi} + {1'b0, r_lo};
        d6    = DW'({delta, 2'b00}) + DW'({delta, 1'b0});
        grey  = (delta == '0);
        case (r_sec)
            SEC_RED: begin
                num = {4'b0, r_pix.green_in} - {4'b0, r_pix.blue_in};
                if (num[DW]) begin
                    num = num + {1'b0, d6};
                end
            end
            SEC_GREEN: begin
                num = {3'b0, delta, 1'b0} + {4'b0, r_pix.blue_in} - {4'b0, r_pix.red_in};
            end
            SEC_BLUE: begin
                num = {2'b0, delta, 2'b00} + {4'b0, r_pix.red_in} - {4'b0, r_pix.green_in};
            end
            default: begin
                num = '0;
            end
        endcase
        sat_den = (sum < CH_FULL) ? sum : (SUM_FULL - sum);

        n_word.valid   = r_v1;
        n_word.sum     = sum;
        n_word.hue.rem = grey ? '0 : {1'b0, num[DW-1:1]};
        n_word.hue.nb  = grey ? 1'b0 : num[0];
        n_word.hue.den = grey ? DW'(1) : d6;
        n_word.hue.quo = '0;
        n_word.sat.rem = DW'(delta[CW-1:1]);
        n_word.sat.nb  = delta[0];
        n_word.sat.den = grey ? DW'(1) : DW'(sat_den);
        n_word.sat.quo = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
        end else begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

>>> src/hsl_div_stage.sv
// One restoring-division stage: one quotient bit for hue and one for saturation.
module hsl_div_stage
    import hsl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_div_word i_word,
    output t_div_word o_word
);

    t_div_word n_word;
    t_div_word r_word;

    always_comb begin
        n_word     = i_word;
        n_word.hue = div_step(i_word.hue);
        n_word.sat = div_step(i_word.sat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
        end else begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

>>> src/rgb_to_hsl_pixel_converter.sv
// Top level: RGB pixel in, HSL word out, fully pipelined.
// Pipeline: two front-end stages plus one divider stage per quotient bit.
// Throughput: one pixel per cycle; busy is low whenever reset is released.
// Reset: synchronous, active low; clears every stage's valid bit, so no strobe follows.
module rgb_to_hsl_pixel_converter
    import hsl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_pix_in  i_pix,
    output logic     o_valid,
    output t_pix_out o_pix
);

    t_div_word w_pipe [QW+1];

    assign busy = !i_rst_n;

    hsl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_pix   (i_pix),
        .o_word  (w_pipe[0])
    );

    for (genvar k = 0; k < QW; k++) begin : g_div
        hsl_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_word  (w_pipe[k]),
            .o_word  (w_pipe[k+1])
        );
    end

    assign o_valid              = w_pipe[QW].valid;
    assign o_pix.hue_out        = 16'(w_pipe[QW].hue.quo);
    assign o_pix.saturation_out = 17'(w_pipe[QW].sat.quo);
    assign o_pix.lightness_sum  = w_pipe[QW].sum;

endmodule

>>> src/hsl_checker.sv
// Port-level checks for the RGB to HSL converter, bound to the top level.
module hsl_checker
    import hsl_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     start,
    input logic     busy,
    input t_pix_in  i_pix,
    input logic     o_valid,
    input t_pix_out o_pix
);

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LATENCY o_valid)
        else $error("accepted word produced no result at fixed latency");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result strobe without an accepted word");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pix.lightness_sum <= 9'd510) && (o_pix.saturation_out <= 17'd65536))
        else $error("lightness or saturation out of range");

    a_grey_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_pix.lightness_sum == 9'd0 || o_pix.lightness_sum == 9'd510)
        |-> (o_pix.hue_out == 16'd0) && (o_pix.saturation_out == 17'd0))
        else $error("black or white pixel with nonzero hue or saturation");

endmodule

bind rgb_to_hsl_pixel_converter hsl_checker u_hsl_checker (.*);
